>>> hdl/tfs_pkg.sv
// Shared types, codes and helpers of the triple redundant field store.
package tfs_pkg;

  localparam int StoreBytes = 2048;
  localparam int FieldIds   = 128;
  localparam int AddrW      = $clog2(StoreBytes);
  localparam int IdW        = $clog2(FieldIds);

  // Action codes on the request port
  localparam logic [2:0] ACT_DEFINE = 3'd0;
  localparam logic [2:0] ACT_READ   = 3'd1;
  localparam logic [2:0] ACT_COPY   = 3'd2;
  localparam logic [2:0] ACT_ADD    = 3'd3;
  localparam logic [2:0] ACT_SUB    = 3'd4;
  localparam logic [2:0] ACT_COMMIT = 3'd5;
  localparam logic [2:0] ACT_SCRUB  = 3'd6;
  localparam logic [2:0] ACT_CLEAR  = 3'd7;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DISAGREE = 3'd1;
  localparam logic [2:0] ST_BAD      = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  typedef enum logic [2:0] {
    OP_DEFINE, OP_READ, OP_COPY, OP_ADD, OP_SUB, OP_COMMIT, OP_SCRUB, OP_CLEAR
  } op_t;

  // Decoded request handed from front to back
  typedef struct packed {
    op_t         op;
    logic        bad_shape;
    logic [6:0]  field_id;
    logic [10:0] element_index;
    logic [31:0] data;
    logic [2:0]  def_width;
    logic [11:0] def_count;
    logic        def_auto;
  } cmd_t;

  typedef struct packed {
    logic [10:0] base;
    logic [2:0]  width;
    logic [11:0] count;
    logic        auto_commit;
  } layout_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LAYOUT, S_RD, S_RDW, S_EXEC, S_WR, S_SCRUB, S_SCRUB_V, S_DONE
  } state_t;

  function automatic logic [31:0] width_mask(input logic [2:0] w);
    case (w)
      3'd1:    width_mask = 32'h0000_00ff;
      3'd2:    width_mask = 32'h0000_ffff;
      3'd3:    width_mask = 32'h00ff_ffff;
      default: width_mask = 32'hffff_ffff;
    endcase
  endfunction

endpackage

>>> hdl/tfs_front.sv
// Request intake: decodes actions and checks define shapes.
module tfs_front import tfs_pkg::*; (
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [6:0]  field_id,
  input  logic [10:0] element_index,
  input  logic [31:0] data,
  input  logic [2:0]  def_width,
  input  logic [11:0] def_count,
  input  logic        def_auto_commit,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  op_t op;

  // action code to operation
  always_comb begin
    case (action)
      ACT_DEFINE: op = OP_DEFINE;
      ACT_READ:   op = OP_READ;
      ACT_COPY:   op = OP_COPY;
      ACT_ADD:    op = OP_ADD;
      ACT_SUB:    op = OP_SUB;
      ACT_COMMIT: op = OP_COMMIT;
      ACT_SCRUB:  op = OP_SCRUB;
      default:    op = OP_CLEAR;
    endcase
  end

  assign in_ready = !rst && !q_full;
  assign q_push   = in_valid && in_ready;

  // build queue entry
  always_comb begin
    q_cmd.op            = op;
    q_cmd.bad_shape     = (def_width == 3'd0) || (def_width > 3'd4) || (def_count == 12'd0);
    q_cmd.field_id      = field_id;
    q_cmd.element_index = element_index;
    q_cmd.data          = data;
    q_cmd.def_width     = def_width;
    q_cmd.def_count     = def_count;
    q_cmd.def_auto      = def_auto_commit;
  end

endmodule

>>> hdl/tfs_queue.sv
// Two-entry request queue between front and back.
module tfs_queue import tfs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic avail,
  output cmd_t head
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full  = (fill == 2'd2);
  assign avail = (fill != 2'd0);
  assign head  = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

endmodule

>>> hdl/tfs_back.sv
// Execution engine: layout table, three byte copies, window and result register.
module tfs_back import tfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr,
  input  logic [10:0] cfg_data,
  input  logic        q_avail,
  input  cmd_t        q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] read_data,
  output logic        flush_valid,
  output logic [10:0] flush_start,
  output logic [11:0] flush_length
);

  state_t state, state_next;

  logic [7:0] copy0 [StoreBytes];
  logic [7:0] copy1 [StoreBytes];
  logic [7:0] copy2 [StoreBytes];
  layout_t    layout_mem [FieldIds];

  logic [7:0]  rdata0, rdata1, rdata2;
  layout_t     lay;
  cmd_t        cmd;
  logic [10:0] scrub_start;
  logic [7:0]  fields_defined;
  logic [11:0] used_bytes;
  logic        dirty;
  logic [11:0] win_start, win_end;
  logic [10:0] elem_addr;
  logic [2:0]  k;
  logic [31:0] v0, v1, v2, nv;
  logic [11:0] scan;
  logic [10:0] clr_cnt;
  logic        clr_report;
  logic [2:0]  p_status;
  logic [31:0] p_rd;
  logic        p_fv;
  logic [10:0] p_fs;
  logic [11:0] p_fl;

  logic        mem_we;
  logic [10:0] mem_addr;
  logic [7:0]  mem_wdata;
  logic        res_free;
  logic        uncorr;
  logic [7:0]  vote;
  logic [14:0] def_prod, def_sum;
  logic [13:0] ix_prod;
  logic [10:0] acc_addr;
  logic        id_bad, is_access, last_byte;
  logic [31:0] nv_calc;
  logic [11:0] ws_new, we_new, addr_end;

  assign res_free  = !out_valid || out_ready;
  assign is_access = (q_head.op == OP_READ) || (q_head.op == OP_COPY) ||
                     (q_head.op == OP_ADD) || (q_head.op == OP_SUB);
  assign id_bad    = ({1'b0, q_head.field_id} >= fields_defined);
  assign def_prod  = {12'd0, q_head.def_width} * {3'd0, q_head.def_count};
  assign def_sum   = {3'd0, used_bytes} + def_prod;
  assign ix_prod   = {3'd0, cmd.element_index} * {11'd0, lay.width};
  assign acc_addr  = lay.base + ix_prod[10:0];
  assign last_byte = (k == lay.width - 3'd1);
  assign q_pop     = (state == S_IDLE) && q_avail;

  // majority vote on one byte
  assign uncorr = (rdata0 != rdata1) && (rdata0 != rdata2) && (rdata1 != rdata2);
  always_comb begin
    if (rdata0 == rdata1 || rdata0 == rdata2) vote = rdata0;
    else vote = rdata1;
  end

  // new element value and window bounds
  always_comb begin
    case (cmd.op)
      OP_COPY: nv_calc = cmd.data;
      OP_ADD:  nv_calc = v0 + cmd.data;
      default: nv_calc = (v0 >= cmd.data) ? v0 - cmd.data : v0;
    endcase
    nv_calc  = nv_calc & width_mask(lay.width);
    addr_end = {1'b0, elem_addr} + {9'd0, lay.width};
    ws_new   = ({1'b0, elem_addr} < win_start) ? {1'b0, elem_addr[10:2], 2'b00} : win_start;
    we_new   = (addr_end > win_end) ? addr_end : win_end;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_cnt == 11'(StoreBytes - 1)) state_next = clr_report ? S_DONE : S_IDLE;
      S_IDLE: begin
        if (q_avail) begin
          if (is_access) state_next = id_bad ? S_DONE : S_LAYOUT;
          else if (q_head.op == OP_SCRUB) state_next = S_SCRUB;
          else if (q_head.op == OP_CLEAR) state_next = S_CLEAR;
          else state_next = S_DONE;
        end
      end
      S_LAYOUT:  state_next = ({1'b0, cmd.element_index} >= lay.count) ? S_DONE : S_RD;
      S_RD:      state_next = S_RDW;
      S_RDW:     state_next = last_byte ? S_EXEC : S_RD;
      S_EXEC: begin
        if (cmd.op == OP_READ || v0 != v1 || v0 != v2) state_next = S_DONE;
        else state_next = S_WR;
      end
      S_WR:      if (last_byte) state_next = S_DONE;
      S_SCRUB:   state_next = (scan >= used_bytes) ? S_DONE : S_SCRUB_V;
      S_SCRUB_V: state_next = uncorr ? S_CLEAR : S_SCRUB;
      S_DONE:    if (res_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // memory port controls
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = elem_addr + {8'd0, k};
    mem_wdata = 8'd0;
    case (state)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt;
      end
      S_WR: begin
        mem_we = 1'b1;
        case (k)
          3'd0:    mem_wdata = nv[7:0];
          3'd1:    mem_wdata = nv[15:8];
          3'd2:    mem_wdata = nv[23:16];
          default: mem_wdata = nv[31:24];
        endcase
      end
      S_SCRUB:   mem_addr = scan[10:0];
      S_SCRUB_V: begin
        mem_we    = !uncorr;
        mem_addr  = scan[10:0];
        mem_wdata = vote;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // byte copies: one port each, same address
  always_ff @(posedge clk) begin
    if (mem_we) begin
      copy0[mem_addr] <= mem_wdata;
      copy1[mem_addr] <= mem_wdata;
      copy2[mem_addr] <= mem_wdata;
    end
    rdata0 <= copy0[mem_addr];
    rdata1 <= copy1[mem_addr];
    rdata2 <= copy2[mem_addr];
  end

  // layout table; the entry of the request being taken is held for its whole run
  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_avail && q_head.op == OP_DEFINE && !q_head.bad_shape &&
        fields_defined < 8'(FieldIds))
      layout_mem[fields_defined[IdW-1:0]] <= {used_bytes[10:0], q_head.def_width,
                                              q_head.def_count, q_head.def_auto};
    if (state == S_IDLE) lay <= layout_mem[q_head.field_id];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_cnt        <= 11'd0;
      clr_report     <= 1'b0;
      scrub_start    <= 11'd0;
      fields_defined <= 8'd0;
      used_bytes     <= 12'd0;
      dirty          <= 1'b0;
      win_start      <= 12'd0;
      win_end        <= 12'd0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr) scrub_start <= cfg_data;
      if (state == S_DONE && res_free) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: clr_cnt <= clr_cnt + 11'd1;
        S_IDLE: begin
          if (q_avail) begin
            cmd      <= q_head;
            p_rd     <= 32'd0;
            scan     <= {1'b0, scrub_start};
            clr_cnt  <= 11'd0;
            clr_report <= 1'b1;
            case (q_head.op)
              OP_DEFINE: begin
                p_fv <= 1'b0;
                p_fs <= 11'd0;
                p_fl <= 12'd0;
                if (q_head.bad_shape) p_status <= ST_BAD;
                else if (fields_defined >= 8'(FieldIds) || def_sum > 15'(StoreBytes))
                  p_status <= ST_FULL;
                else begin
                  p_status       <= ST_OK;
                  fields_defined <= fields_defined + 8'd1;
                  used_bytes     <= def_sum[11:0];
                  if (!dirty) win_start <= def_sum[11:0];
                end
              end
              OP_COMMIT: begin
                p_status <= ST_OK;
                p_fv     <= dirty;
                p_fs     <= dirty ? win_start[10:0] : 11'd0;
                p_fl     <= dirty ? win_end - win_start : 12'd0;
                if (dirty) begin
                  dirty     <= 1'b0;
                  win_end   <= 12'd0;
                  win_start <= used_bytes;
                end
              end
              default: begin
                p_status <= (is_access && id_bad) ? ST_BAD : ST_OK;
                p_fv     <= 1'b0;
                p_fs     <= 11'd0;
                p_fl     <= 12'd0;
              end
            endcase
          end
        end
        S_LAYOUT: begin
          if ({1'b0, cmd.element_index} >= lay.count) p_status <= ST_BAD;
          elem_addr <= acc_addr;
          k  <= 3'd0;
          v0 <= 32'd0;
          v1 <= 32'd0;
          v2 <= 32'd0;
        end
        S_RDW: begin
          v0 <= v0 | ({24'd0, rdata0} << {k, 3'b000});
          v1 <= v1 | ({24'd0, rdata1} << {k, 3'b000});
          v2 <= v2 | ({24'd0, rdata2} << {k, 3'b000});
          k  <= k + 3'd1;
        end
        S_EXEC: begin
          k  <= 3'd0;
          nv <= nv_calc;
          if (cmd.op == OP_READ) p_rd <= v0;
          else if (v0 != v1 || v0 != v2) p_status <= ST_DISAGREE;
          else if (lay.auto_commit) begin
            p_fv      <= 1'b1;
            p_fs      <= ws_new[10:0];
            p_fl      <= we_new - ws_new;
            dirty     <= 1'b0;
            win_end   <= 12'd0;
            win_start <= used_bytes;
          end else begin
            dirty     <= 1'b1;
            win_start <= ws_new;
            win_end   <= we_new;
          end
        end
        S_WR: k <= k + 3'd1;
        S_SCRUB_V: begin
          scan <= scan + 12'd1;
          if (uncorr) p_status <= ST_CLEARED;
        end
        S_DONE: begin
          if (res_free) begin
            status       <= p_status;
            read_data    <= p_rd;
            flush_valid  <= p_fv;
            flush_start  <= p_fs;
            flush_length <= p_fl;
          end
        end
        default: clr_report <= clr_report;
      endcase
    end
  end

  // checks
  a_fields_bounded: assert property (@(posedge clk) disable iff (rst)
    fields_defined <= 8'(FieldIds)) else $error("field count beyond table");
  a_used_bounded: assert property (@(posedge clk) disable iff (rst)
    used_bytes <= 12'(StoreBytes)) else $error("used bytes beyond store");
  a_flush_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && flush_valid |-> status == ST_OK) else $error("flush with error status");
  a_uncorr_clears: assert property (@(posedge clk) disable iff (rst)
    state == S_SCRUB_V && uncorr |=> state == S_CLEAR) else $error("no clear after bad vote");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state != S_IDLE || $past(state_next) == S_IDLE) else $error("pop left idle");

endmodule

>>> hdl/triple_redundant_field_store.sv
// Triple redundant field store: three byte copies with field layout and dirty window.
// A request is taken into a two-entry queue and run one at a time; each gives one
// result. Reads and writes of an element go one byte at a time through the single
// byte port of each copy, and scrub checks the bytes one at a time. Clear and an
// uncorrectable scrub sweep all 2048 bytes, one per cycle; after reset the same
// clearing pass runs before any request is served (scrub_start writes are taken
// throughout).
module triple_redundant_field_store import tfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        scrub_start_wr,
  input  logic [10:0] scrub_start,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [6:0]  field_id,
  input  logic [10:0] element_index,
  input  logic [31:0] data,
  input  logic [2:0]  def_width,
  input  logic [11:0] def_count,
  input  logic        def_auto_commit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] read_data,
  output logic        flush_valid,
  output logic [10:0] flush_start,
  output logic [11:0] flush_length
);

  logic q_full, q_push, q_pop, q_avail;
  cmd_t push_cmd, head;

  tfs_front u_front (
    .rst, .in_valid, .in_ready, .action, .field_id, .element_index, .data,
    .def_width, .def_count, .def_auto_commit,
    .q_full, .q_push, .q_cmd(push_cmd)
  );

  tfs_queue u_queue (
    .clk, .rst, .push(q_push), .push_cmd, .full(q_full),
    .pop(q_pop), .avail(q_avail), .head
  );

  tfs_back u_back (
    .clk, .rst, .cfg_wr(scrub_start_wr), .cfg_data(scrub_start),
    .q_avail, .q_head(head), .q_pop,
    .out_valid, .out_ready, .status, .read_data, .flush_valid, .flush_start, .flush_length
  );

endmodule
